// ===== hdl/fpalloc_pkg.sv =====
// Shared constants, request codes and the token type for the page allocator.
package fpalloc_pkg;

  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned INDEX_SPAN     = 1 << INDEX_W;
  localparam int unsigned DEF_PAGE_COUNT = 1024;

  // each cell owns a slice of 32 consecutive pages
  localparam int unsigned OFF_W      = 5;
  localparam int unsigned CELL_PAGES = 1 << OFF_W;
  localparam int unsigned CELL_IDX_W = INDEX_W - OFF_W;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

  // request travelling down the row of cells
  typedef struct packed {
    logic               valid;
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] page_index;
    logic               done;
    logic               fail;
    logic [INDEX_W-1:0] page;
  } tok_t;

endpackage

// ===== hdl/fpalloc_if.sv =====
// Request and response channel interfaces of the page allocator.
interface fpalloc_req_if;
  import fpalloc_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] page_index;

  modport source (output valid, output mode, output page_index, input ready);
  modport sink (input valid, input mode, input page_index, output ready);
endinterface

interface fpalloc_rsp_if;
  import fpalloc_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [INDEX_W-1:0] result_page;

  modport source (output valid, output status, output result_page, input ready);
  modport sink (input valid, input status, input result_page, output ready);
endinterface

// ===== hdl/fpalloc_cell.sv =====
// One allocator cell: status of a 32-page slice and one stage of the request row.
module fpalloc_cell #(
  parameter int unsigned CELL_ID     = 0,
  parameter int unsigned VALID_PAGES = fpalloc_pkg::CELL_PAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  fpalloc_pkg::tok_t tok_i,
  output fpalloc_pkg::tok_t tok_o
);
  import fpalloc_pkg::*;

  localparam logic [CELL_IDX_W-1:0] CELL_IDX = CELL_IDX_W'(CELL_ID);
  localparam logic [CELL_PAGES-1:0] EXIST_MASK = (VALID_PAGES >= CELL_PAGES) ? '1 :
      CELL_PAGES'((64'd1 << VALID_PAGES) - 64'd1);

  logic [CELL_PAGES-1:0] alloc_q, alloc_d;
  logic [CELL_PAGES-1:0] rsvd_q, rsvd_d;
  logic [CELL_PAGES-1:0] free_vec, first_oh;
  logic [OFF_W-1:0]      first_idx, off;
  logic                  hit;
  tok_t                  tok_q, tok_d;

  always_comb begin
    tok_d    = tok_i;
    alloc_d  = alloc_q;
    rsvd_d   = rsvd_q;
    free_vec = ~alloc_q & ~rsvd_q & EXIST_MASK;
    // isolate the lowest free page
    first_oh  = free_vec & (~free_vec + CELL_PAGES'(1));
    first_idx = '0;
    for (int p = 0; p < CELL_PAGES; p++) begin
      if (first_oh[p]) begin
        first_idx = first_idx | OFF_W'(p);
      end
    end
    off = tok_i.page_index[OFF_W-1:0];
    hit = (tok_i.page_index[INDEX_W-1:OFF_W] == CELL_IDX) && EXIST_MASK[off];

    if (tok_i.valid && !tok_i.done) begin
      case (tok_i.mode)
        MODE_ALLOC: begin
          if (|free_vec) begin
            alloc_d[first_idx] = 1'b1;
            tok_d.done         = 1'b1;
            tok_d.fail         = 1'b0;
            tok_d.page         = {CELL_IDX, first_idx};
          end
        end
        MODE_FREE: begin
          if (hit) begin
            tok_d.done = 1'b1;
            if (alloc_q[off]) begin
              alloc_d[off] = 1'b0;
              tok_d.fail   = 1'b0;
            end
          end
        end
        MODE_RESERVE: begin
          if (hit) begin
            alloc_d[off] = 1'b0;
            rsvd_d[off]  = 1'b1;
            tok_d.done   = 1'b1;
            tok_d.fail   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      rsvd_q  <= '0;
      tok_q   <= '0;
    end else if (adv_i) begin
      alloc_q <= alloc_d;
      rsvd_q  <= rsvd_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/first_free_page_allocator_core.sv =====
// Top level of the first-fit page allocator: request injection, cell row, response register.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+--------------------------
//   req_i    | in  | valid/ready  | mode, page_index
//   rsp_o    | out | valid/ready  | status, result_page
//
// A request enters cell 0 and walks the row one cell per cycle while the row is not held;
// each cell owns 32 pages. One request is in the cell row at a time: it passes every cell
// register of the row and then the response register before it is answered.
// Reset marks every page free at once; no clearing pass is needed.
// A response held by a stalled sink freezes the row once a finished request reaches its end;
// the next request is still accepted as soon as the previous one has left the row.
module first_free_page_allocator_core #(
  parameter int unsigned PAGE_COUNT = fpalloc_pkg::DEF_PAGE_COUNT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  fpalloc_req_if.sink   req_i,
  fpalloc_rsp_if.source rsp_o
);
  import fpalloc_pkg::*;

  // pages beyond the 10-bit index can never be named, so they hold no state
  localparam int unsigned STORED_PAGES = (PAGE_COUNT < INDEX_SPAN) ? PAGE_COUNT : INDEX_SPAN;
  localparam int unsigned NUM_CELLS    = (STORED_PAGES + CELL_PAGES - 1) / CELL_PAGES;

  tok_t                 chain [NUM_CELLS+1];
  logic [NUM_CELLS:0]   tok_valids;
  tok_t                 last;
  logic                 adv;
  logic                 accept;
  logic                 busy_q;
  logic                 out_valid_q;
  logic                 out_status_q;
  logic [INDEX_W-1:0]   out_page_q;

  assign last   = chain[NUM_CELLS];
  // hold the row while the finished request waits for the response slot
  assign adv    = !(last.valid && out_valid_q && !rsp_o.ready);
  assign accept = req_i.valid && !busy_q;

  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = accept;
    chain[0].mode       = req_i.mode;
    chain[0].page_index = req_i.page_index;
    chain[0].fail       = 1'b1;
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    localparam int unsigned REM   = STORED_PAGES - k * CELL_PAGES;
    localparam int unsigned VPAGE = (REM < CELL_PAGES) ? REM : CELL_PAGES;

    fpalloc_cell #(
      .CELL_ID     (k),
      .VALID_PAGES (VPAGE)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  for (genvar k = 0; k <= NUM_CELLS; k++) begin : g_vld
    assign tok_valids[k] = chain[k].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last.valid && adv) begin
        busy_q <= 1'b0;
      end
      if (last.valid && adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.valid && adv) begin
      out_status_q <= last.fail;
      out_page_q   <= last.page;
    end
  end

  assign req_i.ready       = !busy_q;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.result_page = out_page_q;

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valids) <= 1)
    else $error("more than one request in the cell row");

  a_busy_covers_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid |-> busy_q)
    else $error("request in the row while the block reports idle");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("ready stayed high after a request was taken");

  a_fail_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.result_page == '0))
    else $error("failed response carries a nonzero page");

endmodule

// ===== verif/first_free_page_allocator_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the first-fit page allocator: table of probes, then random traffic.
module first_free_page_allocator_core_test;
  import fpalloc_pkg::*;

  localparam int unsigned PAGE_COUNT  = DEF_PAGE_COUNT;
  localparam int unsigned SCAN_PAGES  = (PAGE_COUNT < INDEX_SPAN) ? PAGE_COUNT : INDEX_SPAN;
  localparam int unsigned MIXED_ITEMS = 500;
  localparam int unsigned CHURN_ITEMS = 300;
  localparam int unsigned FULL_EXTRA  = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    PAGE_OPEN  = 2'd0,
    PAGE_TAKEN = 2'd1,
    PAGE_HELD  = 2'd2
  } page_state_e;

  typedef struct packed {
    logic               status;
    logic [INDEX_W-1:0] page;
  } alloc_reply_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] page_index;
    logic               typed;
    logic               status;
    logic [INDEX_W-1:0] page;
  } probe_row_t;

  localparam int unsigned PROBE_ROWS = 24;
  localparam probe_row_t PROBES [PROBE_ROWS] = '{
    '{MODE_ALLOC,   10'd0,    1'b1, STATUS_OK,   10'd0},
    '{MODE_ALLOC,   10'd1023, 1'b1, STATUS_OK,   10'd1},
    '{MODE_FREE,    10'd0,    1'b1, STATUS_OK,   10'd0},
    '{MODE_FREE,    10'd0,    1'b1, STATUS_FAIL, 10'd0},
    '{MODE_ALLOC,   10'h2aa,  1'b1, STATUS_OK,   10'd0},
    '{MODE_RESERVE, 10'd2,    1'b1, STATUS_OK,   10'd0},
    '{MODE_ALLOC,   10'd0,    1'b1, STATUS_OK,   10'd3},
    '{MODE_FREE,    10'd2,    1'b1, STATUS_FAIL, 10'd0},
    '{MODE_RESERVE, 10'd1,    1'b1, STATUS_OK,   10'd0},
    '{MODE_FREE,    10'd1,    1'b1, STATUS_FAIL, 10'd0},
    '{MODE_RESERVE, 10'd1,    1'b1, STATUS_OK,   10'd0},
    '{MODE_UNUSED,  10'd0,    1'b1, STATUS_FAIL, 10'd0},
    '{MODE_UNUSED,  10'd1023, 1'b1, STATUS_FAIL, 10'd0},
    '{MODE_RESERVE, 10'd1023, 1'b1, STATUS_OK,   10'd0},
    '{MODE_FREE,    10'd1023, 1'b1, STATUS_FAIL, 10'd0},
    '{MODE_FREE,    10'd5,    1'b1, STATUS_FAIL, 10'd0},
    '{MODE_ALLOC,   10'h155,  1'b1, STATUS_OK,   10'd4},
    '{MODE_RESERVE, 10'd512,  1'b0, STATUS_OK,   10'd0},
    '{MODE_FREE,    10'd4,    1'b0, STATUS_OK,   10'd0},
    '{MODE_ALLOC,   10'd0,    1'b0, STATUS_OK,   10'd0},
    '{MODE_FREE,    10'd3,    1'b0, STATUS_OK,   10'd0},
    '{MODE_ALLOC,   10'd0,    1'b0, STATUS_OK,   10'd0},
    '{MODE_RESERVE, 10'd0,    1'b0, STATUS_OK,   10'd0},
    '{MODE_ALLOC,   10'd0,    1'b0, STATUS_OK,   10'd0}
  };

  logic clk_i;
  logic rst_ni;

  fpalloc_req_if req_if ();
  fpalloc_rsp_if rsp_if ();

  first_free_page_allocator_core #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  page_state_e  page_state [PAGE_COUNT];
  alloc_reply_t reply_q [$];
  int unsigned  mismatches;
  int unsigned  cycle_count;
  bit           idle_on;
  bit           hold_off_req;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mirror of the page store: apply one request, return the reply it earns.
  function automatic alloc_reply_t apply_request(logic [MODE_W-1:0] m, logic [INDEX_W-1:0] idx);
    alloc_reply_t r;
    int unsigned  i;
    r.status = STATUS_FAIL;
    r.page   = '0;
    case (m)
      MODE_ALLOC: begin
        for (i = 0; i < SCAN_PAGES; i++) begin
          if (page_state[i] == PAGE_OPEN) begin
            page_state[i] = PAGE_TAKEN;
            r.status = STATUS_OK;
            r.page   = INDEX_W'(i);
            break;
          end
        end
      end
      MODE_FREE: begin
        if (idx < PAGE_COUNT && page_state[idx] == PAGE_TAKEN) begin
          page_state[idx] = PAGE_OPEN;
          r.status = STATUS_OK;
        end
      end
      MODE_RESERVE: begin
        if (idx < PAGE_COUNT) begin
          page_state[idx] = PAGE_HELD;
          r.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pick an allocated page, searching up from a random start; any index if none is allocated.
  function automatic logic [INDEX_W-1:0] pick_taken_page();
    int unsigned start;
    int unsigned k;
    int unsigned idx;
    start = $urandom_range(0, PAGE_COUNT - 1);
    for (k = 0; k < PAGE_COUNT; k++) begin
      idx = (start + k) % PAGE_COUNT;
      if (page_state[idx] == PAGE_TAKEN) return INDEX_W'(idx);
    end
    return INDEX_W'(start);
  endfunction

  function automatic bit any_free_page();
    int unsigned i;
    for (i = 0; i < SCAN_PAGES; i++) begin
      if (page_state[i] == PAGE_OPEN) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one beat from a falling edge; return at the falling edge after it is taken.
  task automatic issue(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] idx,
                       input logic typed = 1'b0, input alloc_reply_t typed_reply = '0);
    int unsigned  gap;
    alloc_reply_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.mode       = m;
    req_if.page_index = idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = apply_request(m, idx);
    reply_q.push_back(typed ? typed_reply : predicted);
    @(negedge clk_i);
  endtask

  task automatic issue_mixed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) issue(MODE_ALLOC, INDEX_W'($urandom));
    else if (r < 70) issue(MODE_FREE, pick_taken_page());
    else if (r < 80) issue(MODE_FREE, INDEX_W'($urandom));
    else if (r < 92) issue(MODE_RESERVE, INDEX_W'($urandom));
    else issue(MODE_UNUSED, INDEX_W'($urandom));
  endtask

  task automatic issue_churn();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) issue(MODE_FREE, pick_taken_page());
    else if (r < 85) issue(MODE_ALLOC, INDEX_W'($urandom));
    else if (r < 90) issue(MODE_RESERVE, INDEX_W'($urandom));
    else if (r < 95) issue(MODE_FREE, INDEX_W'($urandom));
    else issue(MODE_UNUSED, INDEX_W'($urandom));
  endtask

  // Response side: short random stalls, and one long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned held;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready = 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk_i);
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(0, 3);
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    alloc_reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply status %0d page %0d", $time, rsp_if.status,
                 rsp_if.result_page);
      end else begin
        want = reply_q.pop_front();
        if (rsp_if.status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                   rsp_if.status);
        end
        if (rsp_if.result_page !== want.page) begin
          mismatches++;
          $display("%0t: result_page mismatch: expected %0d actual %0d", $time, want.page,
                   rsp_if.result_page);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("first_free_page_allocator_core_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    alloc_reply_t typed_reply;
    mismatches        = 0;
    cycle_count       = 0;
    idle_on           = 1'b1;
    hold_off_req      = 1'b0;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_ALLOC;
    req_if.page_index = '0;
    rst_ni            = 1'b0;
    foreach (page_state[i]) page_state[i] = PAGE_OPEN;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (n = 0; n < PROBE_ROWS; n++) begin
      typed_reply.status = PROBES[n].status;
      typed_reply.page   = PROBES[n].page;
      issue(PROBES[n].mode, PROBES[n].page_index, PROBES[n].typed, typed_reply);
    end

    for (n = 0; n < MIXED_ITEMS; n++) begin
      if (n == 150) hold_off_req = 1'b1;
      if (n == 300) begin
        // hold the request side until every reply is back
        req_if.valid = 1'b0;
        while (reply_q.size() != 0) @(negedge clk_i);
      end
      issue_mixed();
    end

    // allocate until the store is full, then past it
    while (any_free_page()) issue(MODE_ALLOC, INDEX_W'($urandom));
    for (n = 0; n < FULL_EXTRA; n++) issue(MODE_ALLOC, INDEX_W'($urandom));

    idle_on = 1'b0;
    for (n = 0; n < CHURN_ITEMS; n++) issue_churn();
    req_if.valid = 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("first_free_page_allocator_core_test passed");
    end else begin
      $display("first_free_page_allocator_core_test failed");
    end
    $finish;
  end

endmodule
